>>> rtl/mlpq_pkg.sv
// Shared types and codes for the multi-level priority queue core.
// No dependencies; every other file imports this package.
package mlpq_pkg;

    // Fixed field widths of the command, response and configuration words.
    localparam int VALUE_W   = 32;
    localparam int LEVEL_W   = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 4;

    // Command operation codes.
    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    // Response status codes.
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_LEVEL = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 4'd1;

    // Result of level selection: whether a level applies, and its 0-based index.
    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] idx;
    } sel_t;

endpackage

>>> rtl/mlpq_if.sv
// Handshake interfaces for the command, response and configuration channels.
// Depends on mlpq_pkg for field widths and code types.
interface mlpq_cmd_if
    import mlpq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    action_t                   action;
    logic [LEVEL_W-1:0]        level;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, action, level, item_value, input ready);
    modport sink   (input valid, action, level, item_value, output ready);
endinterface

interface mlpq_rsp_if
    import mlpq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    status_t                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic [LEVEL_W-1:0]        served_level;

    modport source (output valid, status, out_value, served_level, input ready);
    modport sink   (input valid, status, out_value, served_level, output ready);
endinterface

interface mlpq_cfg_if
    import mlpq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/mlpq_sel.sv
// Level selection: checks an enqueue level or finds the highest-priority
// non-empty level for a dequeue. Depends on mlpq_pkg.
module mlpq_sel
    import mlpq_pkg::*;
#(
    parameter int LEVELS = 8
) (
    input  action_t              action,
    input  logic [LEVEL_W-1:0]   level,
    input  logic [CFG_DAT_W-1:0] num_levels,
    input  logic [LEVELS-1:0]    nonempty,
    output sel_t                 sel
);

    logic [LEVEL_W:0] nl_eff;

    // Clamp the configured level count to the levels that exist.
    always_comb
    begin
        if ((LEVEL_W + 1)'(num_levels) > (LEVEL_W + 1)'(LEVELS))
        begin
            nl_eff = (LEVEL_W + 1)'(LEVELS);
        end
        else
        begin
            nl_eff = (LEVEL_W + 1)'(num_levels);
        end
    end

    // Enqueue validates the named level; dequeue takes the lowest usable
    // non-empty level, so the loop runs downward and the last match wins.
    always_comb
    begin
        sel.hit = 1'b0;
        sel.idx = '0;
        if (action == ACT_ENQ)
        begin
            if (level != '0 && {1'b0, level} <= nl_eff)
            begin
                sel.hit = 1'b1;
                sel.idx = level - 1'b1;
            end
        end
        else
        begin
            for (int i = LEVELS - 1; i >= 0; i--)
            begin
                if (nonempty[i] && (LEVEL_W + 1)'(i) < nl_eff)
                begin
                    sel.hit = 1'b1;
                    sel.idx = LEVEL_W'(i);
                end
            end
        end
    end

endmodule

>>> rtl/multi_level_priority_queue_core.sv
// Top level of the multi-level priority queue: one linear FIFO per level,
// pointers and slots held in synchronous memories. Uses mlpq_pkg, the
// interfaces in mlpq_if and the level selector mlpq_sel.
//
//   channel | dir | word                                   | accepted when
//   cmd     | in  | action, level, item_value              | valid && ready
//   rsp     | out | status, out_value, served_level        | valid && ready
//   cfg     | in  | index, data (num_levels, depth_in_use) | valid && ready
//
// Each command first reads the pointer memory; a dequeue then needs a second
// read from the slot memory.
// Commands are taken one at a time; a new one is taken while the last
// response still waits in the output register.
// Reset clears the non-empty and response valid flags, sets num_levels and
// depth to 8; memories are not cleared, as empty levels' data is unused.
// A stalled response holds the core before it writes its next result.
module multi_level_priority_queue_core
    import mlpq_pkg::*;
#(
    parameter int LEVELS = 8,
    parameter int SLOTS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mlpq_cfg_if.sink    cfg,
    mlpq_cmd_if.sink    cmd,
    mlpq_rsp_if.source  rsp
);

    localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW      = PW + 1;
    localparam int ENTRIES = LEVELS * SLOTS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PTR  = 3'b010,
        S_SLOT = 3'b100
    } state_t;

    // Memories: per-level {head, tail} and the value slots.
    logic [2*PW-1:0]    ptr_mem  [LEVELS];
    logic [VALUE_W-1:0] slot_mem [ENTRIES];

    state_t               state_reg, state_next;
    logic [CFG_DAT_W-1:0] num_levels_reg, num_levels_next;
    logic [CFG_DAT_W-1:0] depth_reg, depth_next;
    logic [LEVELS-1:0]    nonempty_reg, nonempty_next;

    action_t            op_reg;
    logic               hit_reg;
    logic [LW-1:0]      q_reg;
    logic [VALUE_W-1:0] val_reg;

    logic [2*PW-1:0]    ptr_rdata_reg;
    logic [VALUE_W-1:0] slot_rdata_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    status_t            status_reg, status_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [LEVEL_W-1:0] served_reg, served_next;

    sel_t sel;
    logic accept;
    logic out_free;

    logic               ptr_we;
    logic [2*PW-1:0]    ptr_wdata;
    logic               slot_we;
    logic [AW-1:0]      slot_waddr;
    logic               slot_re;
    logic [AW-1:0]      slot_raddr;

    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [7:0]    depth_wide;
    logic [CW-1:0] depth_eff;
    logic          lvl_full;

    function automatic logic [AW-1:0] slot_addr(logic [LW-1:0] q, logic [PW-1:0] p);
        slot_addr = AW'(int'(q) * SLOTS + int'(p));
    endfunction

    mlpq_sel #(
        .LEVELS (LEVELS)
    ) u_sel (
        .action     (cmd.action),
        .level      (cmd.level),
        .num_levels (num_levels_reg),
        .nonempty   (nonempty_reg),
        .sel        (sel)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_value    = out_value_reg;
    assign rsp.served_level = served_reg;

    assign head = ptr_rdata_reg[2*PW-1:PW];
    assign tail = ptr_rdata_reg[PW-1:0];

    // Effective depth: zero acts as one, anything past SLOTS acts as SLOTS.
    always_comb
    begin
        depth_wide = {4'b0, depth_reg};
        if (depth_wide == 8'd0)
        begin
            depth_wide = 8'd1;
        end
        else if (depth_wide > 8'(SLOTS))
        begin
            depth_wide = 8'(SLOTS);
        end
        depth_eff = depth_wide[CW-1:0];
    end

    assign lvl_full = nonempty_reg[q_reg] && ((CW'(tail) + 1'b1) >= depth_eff);

    // Configuration register writes.
    always_comb
    begin
        num_levels_next = num_levels_reg;
        depth_next      = depth_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_NUM_LEVELS: num_levels_next = cfg.data;
                CFG_DEPTH:      depth_next      = cfg.data;
                default:        ;
            endcase
        end
    end

    // Sequencer: pointer read, update and slot access, then the response.
    always_comb
    begin
        state_next     = state_reg;
        nonempty_next  = nonempty_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        served_next    = served_reg;
        ptr_we         = 1'b0;
        ptr_wdata      = ptr_rdata_reg;
        slot_we        = 1'b0;
        slot_waddr     = slot_addr(q_reg, tail);
        slot_re        = 1'b0;
        slot_raddr     = slot_addr(q_reg, head);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PTR;
                end
            end

            S_PTR:
            begin
                if (op_reg == ACT_ENQ)
                begin
                    if (out_free)
                    begin
                        state_next     = S_IDLE;
                        rsp_valid_next = 1'b1;
                        out_value_next = '0;
                        served_next    = '0;
                        if (!hit_reg)
                        begin
                            status_next = STS_BAD_LEVEL;
                        end
                        else if (lvl_full)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            status_next = STS_OK;
                            ptr_we      = 1'b1;
                            slot_we     = 1'b1;
                            if (nonempty_reg[q_reg])
                            begin
                                ptr_wdata  = {head, tail + 1'b1};
                                slot_waddr = slot_addr(q_reg, tail + 1'b1);
                            end
                            else
                            begin
                                ptr_wdata            = '0;
                                slot_waddr           = slot_addr(q_reg, '0);
                                nonempty_next[q_reg] = 1'b1;
                            end
                        end
                    end
                end
                else if (!hit_reg)
                begin
                    if (out_free)
                    begin
                        state_next     = S_IDLE;
                        rsp_valid_next = 1'b1;
                        status_next    = STS_EMPTY;
                        out_value_next = '0;
                        served_next    = '0;
                    end
                end
                else
                begin
                    // Dequeue: read the head slot and advance or drain the level.
                    state_next = S_SLOT;
                    slot_re    = 1'b1;
                    if (head >= tail)
                    begin
                        nonempty_next[q_reg] = 1'b0;
                    end
                    else
                    begin
                        ptr_we    = 1'b1;
                        ptr_wdata = {head + 1'b1, tail};
                    end
                end
            end

            S_SLOT:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = STS_OK;
                    out_value_next = slot_rdata_reg;
                    served_next    = LEVEL_W'(q_reg) + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_levels_reg <= 4'd8;
            depth_reg      <= 4'd8;
            nonempty_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_levels_reg <= num_levels_next;
            depth_reg      <= depth_next;
            nonempty_reg   <= nonempty_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Command capture and response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.action;
            hit_reg <= sel.hit;
            q_reg   <= sel.idx[LW-1:0];
            val_reg <= cmd.item_value;
        end
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        served_reg    <= served_next;
    end

    // Pointer memory: read on accept, written back during the update cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ptr_rdata_reg <= ptr_mem[sel.idx[LW-1:0]];
        end
        if (ptr_we)
        begin
            ptr_mem[q_reg] <= ptr_wdata;
        end
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_raddr];
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= val_reg;
        end
    end

endmodule
